>>> design/sarc_pkg.sv
`timescale 1ns / 1ps

package sarc_pkg;

  // fixed widths of the stream fields
  localparam int unsigned OUT_W   = 5;
  localparam int unsigned MATCH_W = 3;

  // operation codes carried on in_tuser
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [MATCH_W-1:0] MATCH_MAX   = 3'd7;
  localparam logic [MATCH_W-1:0] MATCH_RESET = 3'd3;
  localparam logic [MATCH_W-1:0] MATCH_ONE   = 3'd1;

  // search control state
  typedef struct packed {
    logic [MATCH_W-1:0] match_count;
    logic               reference_reading;
    logic               have_reference;
    logic               running;
  } sarc_ctl_t;

  // one result beat
  typedef struct packed {
    logic [OUT_W-1:0] conversion_result;
    logic             done_res;
    logic             busy_res;
    logic [OUT_W-1:0] ladder_level;
  } sarc_res_t;

endpackage

>>> design/comparator_sar_adc_controller_core.sv
`timescale 1ns / 1ps
// the result beat for an accepted input beat appears on out_* in the next cycle
// throughput: one beat per cycle while the result stream is drained; the whole search
// step is one pass of logic between the search state registers and the output register
// reset: rst_n synchronous active low; clears the search to idle with bounds
// 0 and all-ones, probe at mid-scale minus one, and matches_needed to 3

module comparator_sar_adc_controller_core import sarc_pkg::*; #(
  parameter int unsigned CODE_BITS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration: matches_needed
  input  logic               cfg_we,
  input  logic [MATCH_W-1:0] cfg_wdata,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [0] comparator_out, [7:1] zero
  input  logic               in_tuser,   // [0] operation
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata   // [4:0] ladder_level, [5] busy_res,
                                         // [6] done_res, [11:7] conversion_result,
                                         // [15:12] zero
);

  localparam logic [CODE_BITS-1:0] START_PROBE = {1'b0, {(CODE_BITS-1){1'b1}}};

  // configuration register
  logic [MATCH_W-1:0]   matches_needed_r;

  // search state
  logic [CODE_BITS-1:0] lower_bound_r, lower_bound_nxt;
  logic [CODE_BITS-1:0] upper_bound_r, upper_bound_nxt;
  logic [CODE_BITS-1:0] probe_r, probe_nxt;
  sarc_ctl_t            ctl_r, ctl_nxt;

  // output register
  logic                 out_valid_r;
  sarc_res_t            out_res_r;
  sarc_res_t            res;

  logic                 in_fire;

  // a new beat goes in whenever the output slot is free or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matches_needed_r <= MATCH_RESET;
    end else if (cfg_we) begin
      matches_needed_r <= cfg_wdata;
    end
  end

  // one search step per accepted beat
  sarc_step #(
    .CODE_BITS (CODE_BITS)
  ) u_step (
    .matches_needed  (matches_needed_r),
    .operation       (in_tuser),
    .comparator_out  (in_tdata[0]),
    .lower_bound     (lower_bound_r),
    .upper_bound     (upper_bound_r),
    .probe           (probe_r),
    .ctl             (ctl_r),
    .lower_bound_nxt (lower_bound_nxt),
    .upper_bound_nxt (upper_bound_nxt),
    .probe_nxt       (probe_nxt),
    .ctl_nxt         (ctl_nxt),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_bound_r <= '0;
      upper_bound_r <= '1;
      probe_r       <= START_PROBE;
      ctl_r         <= '0;
    end else if (in_fire) begin
      lower_bound_r <= lower_bound_nxt;
      upper_bound_r <= upper_bound_nxt;
      probe_r       <= probe_nxt;
      ctl_r         <= ctl_nxt;
    end
  end

  // result beat holds until taken; payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_res_r};

  // every accepted beat shows up as a result beat in the next cycle
  a_fire_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted beat produced no result");

  // a finished conversion is never reported as still busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.done_res |-> !out_res_r.busy_res)
    else $error("done and busy together");

  // the result equals the ladder drive on the finishing beat, zero otherwise
  a_result_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.done_res ?
      (out_res_r.conversion_result == out_res_r.ladder_level) :
      (out_res_r.conversion_result == '0)))
    else $error("conversion result inconsistent");

  // the probe never leaves the search window
  a_probe_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (probe_r >= lower_bound_r) && (probe_r <= upper_bound_r))
    else $error("probe outside bounds");

  // a start beat always leaves the search running
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_tuser == OP_START) |=> ctl_r.running)
    else $error("start did not open a conversion");

endmodule

>>> design/sarc_step.sv
`timescale 1ns / 1ps

module sarc_step import sarc_pkg::*; #(
  parameter int unsigned CODE_BITS = 6
) (
  input  logic [MATCH_W-1:0]   matches_needed,
  input  logic                 operation,
  input  logic                 comparator_out,
  input  logic [CODE_BITS-1:0] lower_bound,
  input  logic [CODE_BITS-1:0] upper_bound,
  input  logic [CODE_BITS-1:0] probe,
  input  sarc_ctl_t            ctl,
  output logic [CODE_BITS-1:0] lower_bound_nxt,
  output logic [CODE_BITS-1:0] upper_bound_nxt,
  output logic [CODE_BITS-1:0] probe_nxt,
  output sarc_ctl_t            ctl_nxt,
  output sarc_res_t            res
);

  localparam int unsigned EXT_W = CODE_BITS + OUT_W;
  localparam logic [CODE_BITS-1:0] START_PROBE = {1'b0, {(CODE_BITS-1){1'b1}}};

  logic [MATCH_W-1:0]   need;
  logic [MATCH_W-1:0]   count_upd;
  logic [CODE_BITS-1:0] gap_up;
  logic [CODE_BITS-1:0] gap_dn;
  logic [EXT_W-1:0]     probe_ext;
  logic                 done;

  assign need   = (matches_needed == '0) ? MATCH_ONE : matches_needed;
  assign gap_up = upper_bound - probe;
  assign gap_dn = probe - lower_bound;

  always_comb begin
    lower_bound_nxt = lower_bound;
    upper_bound_nxt = upper_bound;
    probe_nxt       = probe;
    ctl_nxt         = ctl;
    done            = 1'b0;
    count_upd       = '0;
    if (operation == OP_START) begin
      lower_bound_nxt = '0;
      upper_bound_nxt = '1;
      probe_nxt       = START_PROBE;
      ctl_nxt         = '{match_count: '0, reference_reading: 1'b0,
                          have_reference: 1'b0, running: 1'b1};
    end else if (ctl.running) begin
      if (!ctl.have_reference) begin
        ctl_nxt.reference_reading = comparator_out;
        ctl_nxt.have_reference    = 1'b1;
        ctl_nxt.match_count       = '0;
      end else begin
        if (comparator_out == ctl.reference_reading) begin
          count_upd = (ctl.match_count == MATCH_MAX) ? MATCH_MAX
                                                      : ctl.match_count + MATCH_ONE;
        end
        ctl_nxt.match_count       = count_upd;
        ctl_nxt.reference_reading = comparator_out;
        if (count_upd >= need) begin
          if (comparator_out) begin
            lower_bound_nxt = probe;
            probe_nxt       = probe + (gap_up >> 1);
          end else begin
            upper_bound_nxt = probe;
            probe_nxt       = probe - (gap_dn >> 1);
          end
          ctl_nxt.have_reference = 1'b0;
          ctl_nxt.match_count    = '0;
          // search closed: probe landed on a bound
          if (probe_nxt == lower_bound_nxt || probe_nxt == upper_bound_nxt) begin
            ctl_nxt.running = 1'b0;
            done            = 1'b1;
          end
        end
      end
    end
  end

  assign probe_ext = EXT_W'(probe_nxt) >> 1;

  always_comb begin
    res.ladder_level      = probe_ext[OUT_W-1:0];
    res.busy_res          = ctl_nxt.running;
    res.done_res          = done;
    res.conversion_result = done ? probe_ext[OUT_W-1:0] : '0;
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sarc_pkg::*;

  localparam int CODE_BITS = 6;
  localparam logic [CODE_BITS-1:0] START_PROBE = CODE_BITS'((1 << (CODE_BITS - 1)) - 1);
  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_ITEMS = 950;
  localparam int MAX_PRINTS = 20;

  // one input beat: operation on tuser, comparator bit on tdata[0]
  typedef struct packed {
    logic op;
    logic cmp;
  } sar_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [0] comparator_out, [7:1] zero
  logic        in_tuser = 1'b0; // [0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [4:0] ladder, [5] busy, [6] done, [11:7] result

  comparator_sar_adc_controller_core #(
    .CODE_BITS(CODE_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // search predictor: own copy of the controller state
  // ---------------------------------------------------------------------------
  logic [CODE_BITS-1:0] lo_code = '0;
  logic [CODE_BITS-1:0] hi_code = '1;
  logic [CODE_BITS-1:0] probe_code = START_PROBE;
  logic [MATCH_W-1:0]   agree_cnt = '0;
  logic                 last_cmp = 1'b0;
  logic                 ref_taken = 1'b0;
  logic                 converting = 1'b0;
  logic [MATCH_W-1:0]   match_need = MATCH_RESET;

  // advance the search by one beat and return the result beat it produces
  function automatic sarc_res_t sar_search_step(logic op, logic cmp);
    sarc_res_t r;
    logic [MATCH_W-1:0] need;
    r = '0;
    // a zero requirement behaves as one
    need = (match_need == '0) ? MATCH_ONE : match_need;
    if (op == OP_START) begin
      // start (also mid-conversion) reopens the full range
      lo_code = '0;
      hi_code = '1;
      probe_code = START_PROBE;
      agree_cnt = '0;
      last_cmp = 1'b0;
      ref_taken = 1'b0;
      converting = 1'b1;
    end else if (converting) begin
      if (!ref_taken) begin
        // first sample after a ladder move is only the reference
        last_cmp = cmp;
        ref_taken = 1'b1;
        agree_cnt = '0;
      end else begin
        if (cmp == last_cmp) begin
          if (agree_cnt != MATCH_MAX) agree_cnt = agree_cnt + 1'b1;
        end else begin
          agree_cnt = '0;
        end
        last_cmp = cmp;
        if (agree_cnt >= need) begin
          if (cmp) begin
            lo_code = probe_code;
            probe_code = probe_code + ((hi_code - probe_code) >> 1);
          end else begin
            hi_code = probe_code;
            probe_code = probe_code - ((probe_code - lo_code) >> 1);
          end
          ref_taken = 1'b0;
          agree_cnt = '0;
          // probe landed on a bound: conversion finished
          if (probe_code == lo_code || probe_code == hi_code) begin
            converting = 1'b0;
            r.done_res = 1'b1;
            r.conversion_result = OUT_W'(probe_code >> 1);
          end
        end
      end
    end
    // a sample while idle leaves everything as is
    r.ladder_level = OUT_W'(probe_code >> 1);
    r.busy_res = converting;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // shared bookkeeping
  // ---------------------------------------------------------------------------
  sar_item_t stim_q[$];      // beats waiting for the driver
  sarc_res_t ladder_exp[$];  // predicted result beats, oldest first
  int        errors = 0;
  int        beats_in = 0;
  int        beats_out = 0;
  int        conversions_done = 0;
  int        settings_used = 0;
  int        cycles = 0;
  bit        idle_on = 1'b0; // random gaps and stalls allowed

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // driver: feeds input beats from stim_q, with random gaps
  // ---------------------------------------------------------------------------
  int tx_gap = 0;

  always @(posedge clk) begin : drive_in
    sar_item_t b;
    if (rst_n) begin
      // beat accepted at this edge: predict its result now
      if (in_tvalid && in_tready) begin
        ladder_exp.push_back(sar_search_step(in_tuser, in_tdata[0]));
        beats_in++;
      end
      if (in_tvalid && !in_tready) begin
        // hold the beat until taken
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        // random-length gap starting now
        tx_gap = $urandom_range(1, 13) - 1;
        in_tvalid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        b = stim_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= b.op;
        in_tdata  <= {7'b0, b.cmp};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, checks every result beat
  // ---------------------------------------------------------------------------
  int rx_stall = 0;

  always @(posedge clk) begin : watch_out
    sarc_res_t got;
    sarc_res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = sarc_res_t'(out_tdata[11:0]);
        beats_out++;
        if (ladder_exp.size() == 0) begin
          report_mismatch("unexpected result beat", int'(out_tdata), -1);
        end else begin
          want = ladder_exp.pop_front();
          if (got.ladder_level != want.ladder_level)
            report_mismatch("ladder_level", got.ladder_level, want.ladder_level);
          if (got.busy_res != want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
          if (got.done_res != want.done_res)
            report_mismatch("done_res", got.done_res, want.done_res);
          if (got.conversion_result != want.conversion_result)
            report_mismatch("conversion_result", got.conversion_result,
                            want.conversion_result);
          if (want.done_res) conversions_done++;
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        rx_stall = $urandom_range(1, 13) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycles,
               ladder_exp.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  int         items_queued = 0;
  logic [2:0] gen_need = MATCH_RESET; // setting the generator shapes runs for

  task automatic push_beat(logic op, logic cmp);
    stim_q.push_back('{op: op, cmp: cmp});
    items_queued++;
  endtask

  // block is idle: nothing queued, nothing on the bus, nothing outstanding
  task automatic wait_quiet();
    do @(negedge clk);
    while (stim_q.size() != 0 || in_tvalid || ladder_exp.size() != 0);
  endtask

  task automatic set_match_need(logic [2:0] v);
    wait_quiet();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    match_need = v;
    gen_need = v;
    settings_used++;
    @(negedge clk);
  endtask

  // reference sample plus enough agreeing samples to force one decision, unless a sample disagrees
  task automatic push_decision(logic bit_val);
    int n;
    int flip_at;
    n = ((gen_need == 0) ? 1 : gen_need) + 1;
    // now and then one sample disagrees, which restarts the agreement count
    flip_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++)
      push_beat(OP_SAMPLE, (i == flip_at) ? ~bit_val : bit_val);
  endtask

  task automatic push_noise(int count);
    for (int i = 0; i < count; i++)
      push_beat(($urandom_range(0, 4) == 0) ? OP_START : OP_SAMPLE, 1'($urandom));
  endtask

  // start plus enough decisions to finish any 6-bit search
  task automatic push_conversion();
    push_beat(OP_START, 1'($urandom));
    for (int d = 0; d < CODE_BITS; d++) begin
      push_decision(1'($urandom));
      // occasional restart in the middle of a search
      if ($urandom_range(0, 39) == 0) push_beat(OP_START, 1'($urandom));
    end
    if ($urandom_range(0, 9) == 0) push_noise($urandom_range(1, 6));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: single-match decisions
    set_match_need(3'd1);
    push_beat(OP_SAMPLE, 1'b1);  // samples while idle are ignored
    push_beat(OP_SAMPLE, 1'b0);
    push_beat(OP_START, 1'b0);
    push_beat(OP_SAMPLE, 1'b1);  // reference
    push_beat(OP_SAMPLE, 1'b1);  // agrees: step up
    push_beat(OP_SAMPLE, 1'b0);  // reference
    push_beat(OP_SAMPLE, 1'b1);  // disagrees, count cleared
    push_beat(OP_SAMPLE, 1'b1);  // agrees: step up
    push_beat(OP_START, 1'b1);   // restart while running
    for (int i = 0; i < 6; i++) begin
      push_beat(OP_SAMPLE, 1'b0); // walk all the way down to code zero
      push_beat(OP_SAMPLE, 1'b0);
    end
    push_beat(OP_SAMPLE, 1'b0);  // after done: idle again

    // directed: zero requirement behaves as one, a single step up from the start probe
    set_match_need(3'd0);
    push_beat(OP_START, 1'b0);
    push_beat(OP_SAMPLE, 1'b1);
    push_beat(OP_SAMPLE, 1'b1);

    // random phases, extremes first, with random idling
    idle_on = 1'b1;
    set_match_need(3'd7);
    repeat (3) push_conversion();
    set_match_need(3'd0);
    repeat (4) push_conversion();
    while (items_queued < TARGET_ITEMS - 80) begin
      set_match_need(3'($urandom_range(0, 7)));
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 5)) push_conversion();
      if ($urandom_range(0, 2) == 0) push_noise($urandom_range(2, 10));
    end

    // last stretch at the reset setting, no idling on either side
    idle_on = 1'b0;
    set_match_need(MATCH_RESET);
    while (items_queued < TARGET_ITEMS) push_conversion();

    wait_quiet();
    repeat (4) @(posedge clk);
    $display("covered %0d beats in, %0d beats out, %0d finished conversions",
             beats_in, beats_out, conversions_done);
    $display("across %0d match settings, %0d mismatches", settings_used, errors);
    if (errors == 0 && ladder_exp.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
